// ===== rtl/block_sad_with_threshold_assert.svh =====
// Assertion macros for the checker file of the block SAD design.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BLOCK_SAD_WITH_THRESHOLD_ASSERT_SVH
`define BLOCK_SAD_WITH_THRESHOLD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SADT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SADT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sadt_pkg.sv =====
`timescale 1ns / 1ps

package sadt_pkg;

    localparam int BLOCK_ROWS = 8;
    localparam int LANES      = 8;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 64;
    localparam int SUM_W     = 14;
    localparam int MODE_W    = 2;
    localparam int ROW_SUM_W = PIX_W + $clog2(LANES + 1);
    localparam int ROW_CNT_W = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Largest sum a block can produce, after saturation.
    localparam int SAD_RAW  = BLOCK_ROWS * LANES * ((1 << PIX_W) - 1);
    localparam int SAD_PEAK = (SAD_RAW > int'(SUM_MAX)) ? int'(SUM_MAX) : SAD_RAW;

    localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG   = 2'd2;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef pix_t [LANES-1:0]     lane_vec_t;
    typedef logic [ROW_SUM_W-1:0] row_sum_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [ROW_CNT_W-1:0] row_cnt_t;
    typedef logic [MODE_W-1:0]    mode_t;

    // Per-row control that travels alongside the pixel data.
    typedef struct packed {
        logic first;
        logic last;
        logic stop_mode;
        sum_t limit;
    } row_ctl_t;

endpackage

// ===== rtl/sadt_lane.sv =====
`timescale 1ns / 1ps

// One pixel column: optional averaging of the two references, then the
// absolute difference against the source pixel, registered.
module sadt_lane
    import sadt_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  pix_t src_pix,
    input  pix_t ref1_pix,
    input  pix_t ref2_pix,
    input  logic avg,
    output pix_t diff
);

    logic [PIX_W:0] pair_sum;
    pix_t           ref_pix;
    pix_t           diff_next;
    pix_t           diff_reg;

    always_comb
    begin
        pair_sum  = {1'b0, ref1_pix} + {1'b0, ref2_pix};
        ref_pix   = avg ? pair_sum[PIX_W:1] : ref1_pix;
        diff_next = (src_pix > ref_pix) ? (src_pix - ref_pix) : (ref_pix - src_pix);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

// ===== rtl/sadt_merge.sv =====
`timescale 1ns / 1ps

// Adds the lane differences of one row into a registered row sum.
module sadt_merge
    import sadt_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  lane_vec_t diffs,
    output row_sum_t  row_sum
);

    row_sum_t row_sum_next;
    row_sum_t row_sum_reg;

    always_comb
    begin
        row_sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            row_sum_next = row_sum_next + row_sum_t'(diffs[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_sum_reg <= row_sum_next;
        end
    end

    assign row_sum = row_sum_reg;

endmodule

// ===== rtl/block_sad_with_threshold.sv =====
// Block SAD with early stop: one pixel row is accepted per cycle while in_stall is low,
// with no gaps between blocks. The result of a block passes through the lane registers,
// the row adder register and then the output register, loaded together with the accumulator.
// Throughput: one row per cycle while nothing stalls, so one result per BLOCK_ROWS rows.
// Reset (rst_n, asynchronous, active low) empties the pipeline and starts a new block.
`timescale 1ns / 1ps

// Structure
// The row first passes through LANES copies of the difference lane, each of which
// handles one pixel column and registers its absolute difference. The merge stage
// then adds the lane results into a registered row sum. The accumulator stage adds
// that row sum to the running block sum, saturates it, and applies the early stop
// test. Once a block has stopped, its later rows still count towards the block
// length but leave the sum untouched.
//
// The mode and the threshold are taken from the first row of each block and held
// for the rest of it, so that mode and threshold inputs on later rows have no effect.
//
// Flow control
// Only the last row of a block produces an output beat. Only that row can therefore
// be held up by a stalled output register. Every other row drains straight into the
// accumulator. The input is stalled only when the pipeline is full behind such a
// held-up last row. In particular, a new row is still accepted while a finished
// result waits to be taken.
module block_sad_with_threshold
    import sadt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] op,
    input  logic [ROW_W-1:0]  src_row,
    input  logic [ROW_W-1:0]  ref1_row,
    input  logic [ROW_W-1:0]  ref2_row,
    input  logic [SUM_W-1:0]  thresh,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [SUM_W-1:0]  sad,
    output logic              stopped_early
);

    // Input side: row counter and the block settings sampled on the first row.
    row_cnt_t  row_cnt_reg;
    row_cnt_t  row_cnt_next;
    mode_t     mode_reg;
    sum_t      limit_reg;
    mode_t     mode_cur;
    sum_t      limit_cur;
    logic      first_in;
    logic      last_in;
    logic      stop_in;
    logic      in_accept;

    // Pipeline valid flags and control that follows each row.
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    row_ctl_t  s1_ctl_reg;
    row_ctl_t  s2_ctl_reg;
    row_ctl_t  in_ctl;
    logic      s1_can_load;
    logic      s2_can_load;
    logic      s2_adv;
    logic      out_free;

    // Datapath between the stages.
    lane_vec_t lane_diff;
    row_sum_t  row_sum;

    // Accumulator and output register.
    sum_t           sum_reg;
    sum_t           sum_next;
    logic           halted_reg;
    logic           halted_next;
    sum_t           sum_base;
    logic           halted_base;
    logic [SUM_W:0] sum_wide;
    sum_t           sum_sat;
    logic           out_valid_reg;
    logic           out_valid_next;
    sum_t           sad_reg;
    logic           stopped_reg;

    // The input row is taken whenever the first stage is empty or moving on.
    assign out_free    = !out_valid_reg || !out_stall;
    assign s2_adv      = s2_valid_reg && (!s2_ctl_reg.last || out_free);
    assign s2_can_load = !s2_valid_reg || s2_adv;
    assign s1_can_load = !s1_valid_reg || s2_can_load;
    assign in_stall    = !s1_can_load;
    assign in_accept   = in_valid && s1_can_load;

    // Block settings for the row at the input.
    always_comb
    begin
        first_in  = (row_cnt_reg == '0);
        last_in   = (row_cnt_reg == row_cnt_t'(BLOCK_ROWS - 1));
        mode_cur  = first_in ? op : mode_reg;
        limit_cur = first_in ? thresh : limit_reg;

        unique case (mode_cur)
            MODE_STOP, MODE_AVG: stop_in = 1'b1;
            default:             stop_in = 1'b0;
        endcase

        row_cnt_next = last_in ? '0 : row_cnt_reg + row_cnt_t'(1);

        in_ctl.first     = first_in;
        in_ctl.last      = last_in;
        in_ctl.stop_mode = stop_in;
        in_ctl.limit     = limit_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            mode_reg    <= MODE_PLAIN;
            limit_reg   <= '0;
        end
        else if (in_accept)
        begin
            row_cnt_reg <= row_cnt_next;
            mode_reg    <= mode_cur;
            limit_reg   <= limit_cur;
        end
    end

    // Lane stage: one difference unit per pixel column.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        sadt_lane u_lane (
            .clk      (clk),
            .en       (in_accept),
            .src_pix  (src_row[i*PIX_W +: PIX_W]),
            .ref1_pix (ref1_row[i*PIX_W +: PIX_W]),
            .ref2_pix (ref2_row[i*PIX_W +: PIX_W]),
            .avg      (mode_cur == MODE_AVG),
            .diff     (lane_diff[i])
        );
    end

    // Merge stage: the lane results are summed into one row total.
    sadt_merge u_merge (
        .clk     (clk),
        .en      (s1_valid_reg && s2_can_load),
        .diffs   (lane_diff),
        .row_sum (row_sum)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_can_load)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_valid_reg && s2_can_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ctl_reg <= in_ctl;
        end
        if (s1_valid_reg && s2_can_load)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // Accumulator: the first row of a block restarts the sum. Once a block has
    // stopped, the sum and the stop flag stay frozen until the block ends.
    always_comb
    begin
        sum_base    = s2_ctl_reg.first ? '0 : sum_reg;
        halted_base = s2_ctl_reg.first ? 1'b0 : halted_reg;
        sum_wide    = {1'b0, sum_base} + (SUM_W + 1)'(row_sum);
        sum_sat     = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

        if (halted_base)
        begin
            sum_next    = sum_base;
            halted_next = 1'b1;
        end
        else
        begin
            sum_next    = sum_sat;
            halted_next = s2_ctl_reg.stop_mode && (sum_sat > s2_ctl_reg.limit);
        end

        out_valid_next = out_valid_reg;
        if (s2_adv && s2_ctl_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
            begin
                sum_reg    <= sum_next;
                halted_reg <= halted_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_ctl_reg.last)
        begin
            sad_reg     <= sum_next;
            stopped_reg <= halted_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sad           = sad_reg;
    assign stopped_early = stopped_reg;

endmodule

// ===== rtl/sadt_checker.sv =====
`timescale 1ns / 1ps
`include "block_sad_with_threshold_assert.svh"

// Watches the ports of the block SAD unit.
module sadt_checker
    import sadt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [SUM_W-1:0] sad,
    input logic             stopped_early
);

    // A row is only refused when a finished result is waiting on a stalled output.
    `SADT_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a waiting result")

    // A stop means the sum went past a threshold, so the sum cannot be zero.
    `SADT_ASSERT_SAME(a_stop_nonzero, out_valid && stopped_early, sad != '0, "early stop reported with a zero sum")

    // The sum never goes beyond what a full block of maximal differences gives.
    `SADT_ASSERT_SAME(a_sad_range, out_valid, sad <= SUM_W'(SAD_PEAK), "sum beyond the largest possible block sum")

    // A result that is held back stays on the port unchanged.
    `SADT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sad) && $stable(stopped_early), "held result changed or vanished")

endmodule

bind block_sad_with_threshold sadt_checker u_sadt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sad           (sad),
    .stopped_early (stopped_early)
);
